/* hw/rtl/line_follower_marker_sequencer_macros.svh */
// assertion macros shared by the line follower marker sequencer rtl
`ifndef LINE_FOLLOWER_MARKER_SEQUENCER_MACROS_SVH
`define LINE_FOLLOWER_MARKER_SEQUENCER_MACROS_SVH

// plain property checked on every clock edge outside reset
`define LFMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication checked on every clock edge outside reset
`define LFMS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/lfms_pkg.sv */
// types, codes and constants for the line follower marker sequencer
`timescale 1ns / 1ps

package lfms_pkg;

    // item kinds
    localparam logic [1:0] FUNC_SAMPLE      = 2'd0;
    localparam logic [1:0] FUNC_LEFT_PULSE  = 2'd1;
    localparam logic [1:0] FUNC_RIGHT_PULSE = 2'd2;
    localparam logic [1:0] FUNC_RX_BYTE     = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAFT_LIMIT     = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_WHITE_THRESHOLD = 8'd40;
    localparam logic [7:0]  RST_FAST_SPEED      = 8'd120;
    localparam logic [7:0]  RST_MEDIUM_SPEED    = 8'd100;
    localparam logic [7:0]  RST_SLOW_SPEED      = 8'd80;
    localparam logic [15:0] RST_SHAFT_LIMIT     = 16'd10;

    // pattern codes
    localparam logic [2:0] PAT_NONE       = 3'd0;
    localparam logic [2:0] PAT_ALL        = 3'd1;
    localparam logic [2:0] PAT_RIGHT_MID  = 3'd2;
    localparam logic [2:0] PAT_MID_LEFT   = 3'd3;
    localparam logic [2:0] PAT_RIGHT      = 3'd4;
    localparam logic [2:0] PAT_LEFT       = 3'd5;
    localparam logic [2:0] PAT_MID        = 3'd6;
    localparam logic [2:0] PAT_OFF_LINE   = 3'd7;

    localparam logic [7:0]  RESUME_BYTE = 8'h38;
    localparam logic [15:0] DONE_MARK   = 16'd99;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] right_level;
        logic [7:0] middle_level;
        logic [7:0] left_level;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  left_speed;
        logic [7:0]  right_speed;
        logic        forward;
        logic [2:0]  pattern_code;
        logic [15:0] marker_count;
        logic        tx_valid;
        logic [3:0]  tx_data;
        logic        buzzer;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  white_threshold;
        logic [7:0]  fast_speed;
        logic [7:0]  medium_speed;
        logic [7:0]  slow_speed;
        logic [15:0] shaft_limit;
    } t_cfg;

    typedef struct packed {
        logic [15:0] marker_count;
        logic        following;
        logic        black_armed;
        logic        travel_done;
        logic [15:0] left_pulses;
        logic [15:0] right_pulses;
        logic        send_pending;
        logic [7:0]  left_drive;
        logic [7:0]  right_drive;
        logic        forward;
        logic        buzzer;
        logic [2:0]  pattern;
    } t_state;

endpackage

/* hw/rtl/lfms_step.sv */
// next-state and result logic for one item
`timescale 1ns / 1ps

module lfms_step (
    input  lfms_pkg::t_state    i_state,
    input  lfms_pkg::t_cfg      i_cfg,
    input  lfms_pkg::t_in_item  i_item,
    output lfms_pkg::t_state    o_state,
    output lfms_pkg::t_out_item o_result
);
    import lfms_pkg::*;

    logic        on_r;
    logic        on_m;
    logic        on_l;
    logic        sent;
    logic [15:0] pulse_cnt;

    assign on_r = i_item.right_level  < i_cfg.white_threshold;
    assign on_m = i_item.middle_level < i_cfg.white_threshold;
    assign on_l = i_item.left_level   < i_cfg.white_threshold;

    // shared incrementer for whichever shaft pulsed
    assign pulse_cnt = ((i_item.func == FUNC_LEFT_PULSE) ? i_state.left_pulses
                                                         : i_state.right_pulses) + 16'd1;

    always_comb begin
        o_state = i_state;
        sent    = 1'b0;
        case (i_item.func)
            FUNC_SAMPLE: begin
                if (i_state.following && (on_r || on_m || on_l)) begin
                    o_state.forward     = 1'b1;
                    o_state.black_armed = 1'b1;
                    if (on_r && on_m && on_l) begin
                        o_state.pattern     = PAT_ALL;
                        o_state.left_drive  = i_cfg.fast_speed;
                        o_state.right_drive = i_cfg.fast_speed;
                    end else if (on_r && on_m) begin
                        o_state.pattern     = PAT_RIGHT_MID;
                        o_state.left_drive  = i_cfg.fast_speed;
                        o_state.right_drive = i_cfg.medium_speed;
                    end else if (on_m && on_l) begin
                        o_state.pattern     = PAT_MID_LEFT;
                        o_state.left_drive  = i_cfg.medium_speed;
                        o_state.right_drive = i_cfg.fast_speed;
                    end else if (on_r) begin
                        o_state.pattern     = PAT_RIGHT;
                        o_state.left_drive  = i_cfg.fast_speed;
                        o_state.right_drive = i_cfg.slow_speed;
                    end else if (on_l) begin
                        o_state.pattern     = PAT_LEFT;
                        o_state.left_drive  = i_cfg.slow_speed;
                        o_state.right_drive = i_cfg.fast_speed;
                    end else begin
                        o_state.pattern     = PAT_MID;
                        o_state.left_drive  = i_cfg.fast_speed;
                        o_state.right_drive = i_cfg.fast_speed;
                    end
                end else begin
                    o_state.pattern = PAT_OFF_LINE;
                    if (i_state.black_armed) begin
                        // leaving a black marker
                        o_state.marker_count = i_state.marker_count + 16'd1;
                        o_state.black_armed  = 1'b0;
                        o_state.travel_done  = 1'b0;
                        o_state.left_pulses  = 16'd0;
                        o_state.right_pulses = 16'd0;
                        o_state.following    = 1'b0;
                    end else if (i_state.travel_done) begin
                        o_state.left_drive   = 8'd0;
                        o_state.right_drive  = 8'd0;
                        o_state.marker_count = DONE_MARK;
                    end else if (!i_state.following && (on_r || on_m || on_l)) begin
                        o_state.left_drive  = 8'd0;
                        o_state.right_drive = 8'd0;
                        if (i_state.send_pending) begin
                            sent                 = 1'b1;
                            o_state.send_pending = 1'b0;
                        end
                    end
                end
            end
            FUNC_LEFT_PULSE: begin
                o_state.left_pulses = pulse_cnt;
                if (pulse_cnt > i_cfg.shaft_limit) begin
                    o_state.travel_done = 1'b1;
                end
            end
            FUNC_RIGHT_PULSE: begin
                o_state.right_pulses = pulse_cnt;
                if (pulse_cnt > i_cfg.shaft_limit) begin
                    o_state.travel_done = 1'b1;
                end
            end
            FUNC_RX_BYTE: begin
                if (i_item.rx_byte == RESUME_BYTE) begin
                    o_state.buzzer       = 1'b1;
                    o_state.following    = 1'b1;
                    o_state.send_pending = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    always_comb begin
        o_result.left_speed   = o_state.left_drive;
        o_result.right_speed  = o_state.right_drive;
        o_result.forward      = o_state.forward;
        o_result.pattern_code = o_state.pattern;
        o_result.marker_count = o_state.marker_count;
        o_result.tx_valid     = sent;
        o_result.tx_data      = sent ? o_state.marker_count[3:0] : 4'd0;
        o_result.buzzer       = o_state.buzzer;
    end

endmodule

/* hw/rtl/line_follower_marker_sequencer.sv */
// line follower marker sequencer top level: handshakes, registers, state
`timescale 1ns / 1ps
`include "line_follower_marker_sequencer_macros.svh"

// Takes one item per clock when results are taken (sensor sample, left or right
// shaft pulse, or a received byte) and returns exactly one result per item,
// showing the motor speeds, forward flag, last pattern, marker count, any
// position nibble sent and the buzzer after that item. An accepted item is held
// in the input register while the step logic computes the new state, and its
// result is registered in the output register when the step advances; the
// input stalls while both registers are full and the output is not taken.
// The throughput is set by the single combinational pass from the input
// register to the state and result registers. Configuration writes (index 0
// white threshold, 1 fast, 2 medium, 3 slow speed, 4 shaft limit) take effect
// at once and are meant for idle periods; other indexes are ignored.
module line_follower_marker_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lfms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfms_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lfms_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lfms_pkg::t_out_item               o_out_data
);
    import lfms_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      w_adv;

    // step the held item when the result slot is free or being emptied
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    lfms_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_threshold <= RST_WHITE_THRESHOLD;
            r_cfg.fast_speed      <= RST_FAST_SPEED;
            r_cfg.medium_speed    <= RST_MEDIUM_SPEED;
            r_cfg.slow_speed      <= RST_SLOW_SPEED;
            r_cfg.shaft_limit     <= RST_SHAFT_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WHITE_THRESHOLD: r_cfg.white_threshold <= i_cfg_wdata[7:0];
                CFG_FAST_SPEED:      r_cfg.fast_speed      <= i_cfg_wdata[7:0];
                CFG_MEDIUM_SPEED:    r_cfg.medium_speed    <= i_cfg_wdata[7:0];
                CFG_SLOW_SPEED:      r_cfg.slow_speed      <= i_cfg_wdata[7:0];
                CFG_SHAFT_LIMIT:     r_cfg.shaft_limit     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LFMS_ASSERT_IMPL(a_stall_only_when_full, !o_in_ready, r_in_valid && r_out_valid,
        "input stalled while a register stage is free")
    `LFMS_ASSERT_IMPL(a_sent_clears_pending, r_out_valid && r_out.tx_valid,
        !r_state.send_pending, "position sent but send still pending")
    `LFMS_ASSERT_IMPL(a_steer_sets_forward,
        r_state.pattern != PAT_NONE && r_state.pattern != PAT_OFF_LINE, r_state.forward,
        "steering pattern recorded without forward command")
    `LFMS_ASSERT(a_state_holds, ($past(i_rst_n) && !$past(w_adv)) |-> $stable(r_state),
        "state changed without a step")
    `LFMS_ASSERT(a_sample_sets_pattern,
        (w_adv && r_in.func == FUNC_SAMPLE) |=> (r_state.pattern != PAT_NONE),
        "sensor sample left no pattern")

endmodule
